/* sv/stp_pkg.sv */
// Shared types, codes and constants of the software timer pool.
`timescale 1ns / 1ps
package stp_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int PERIOD_W      = 15;
	localparam int REM_W         = 17;
	localparam int STEP_W        = 10;
	localparam int SLOT_W        = 3;
	localparam int MASK_W        = 8;
	localparam logic [STEP_W-1:0] TICK_STEP_RESET = STEP_W'(10);

	// input action codes
	typedef enum logic [1:0] {
		ACT_TICK     = 2'd0,
		ACT_ONESHOT  = 2'd1,
		ACT_PERIODIC = 2'd2,
		ACT_SERVICE  = 2'd3
	} action_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_PER  = 2'd1,
		ST_POOL_FULL = 2'd2
	} status_t;

	// one slot entry as kept in the slot memory
	typedef struct packed {
		logic                       oneshot;
		logic [PERIOD_W-1:0]        period;
		logic signed [REM_W-1:0]    remaining;
	} entry_t;

	// value of an entry that was never written
	localparam entry_t RESET_ENTRY = '{oneshot: 1'b1, period: '0, remaining: '0};

	// outcome of one slot update
	typedef struct packed {
		entry_t nxt;
		logic   fire;
		logic   run;
	} upd_t;

endpackage

/* sv/software_timer_pool.sv */
// Top level of the software timer pool: handshakes, sweep control, slot memory.
//
//  channel   dir  handshake        payload
//  s_*       in   tvalid/tready    tuser: action; tdata: period_ms
//  m_*       out  tvalid/tready    tuser: status; tdata: slot, fired_mask
//  p*        in   APB write/read   reg 0 at 0x0: tick_step_ms
//
// Tick and service walk every slot through the slot memory, one read per
// cycle plus one write-back. Registration scans the running flags, one slot
// per cycle. A zero period goes straight to the result without a scan. The
// next item is taken when the block returns to idle, even while the previous
// result still waits on m_tready. Reset clears running and entry-valid flags;
// no clearing pass is needed.
`timescale 1ns / 1ps
module software_timer_pool
	import stp_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [14:0] period_ms, [15] zero
	input  logic [1:0]  s_tuser,   // [1:0] action
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [2:0] slot, [10:3] fired_mask, [15:11] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SWEEP,
		S_DRAIN,
		S_DONE
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [1:0]           act_q;
	logic [PERIOD_W-1:0]  per_q;
	logic [STEP_W-1:0]    step_q;
	logic [NUM_SLOTS-1:0] running_q;
	logic [NUM_SLOTS-1:0] vld_q;
	logic [1:0]           res_status_q;
	logic [SLOT_W-1:0]    res_slot_q;
	logic [MASK_W-1:0]    fired_q;
	logic                 m_valid_q;
	logic [1:0]           m_status_q;
	logic [SLOT_W-1:0]    m_slot_q;
	logic [MASK_W-1:0]    m_fired_q;

	// read pipeline stage
	logic                 v_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 vld_s1;
	entry_t               rdata_s1;
	entry_t               cur_s1;

	entry_t               slot_mem [NUM_SLOTS];
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	entry_t               wr_data;
	upd_t                 upd;

	logic                 in_acc;
	logic                 cfg_wr;
	logic                 is_reg_act;

	assign in_acc     = s_tvalid && s_tready;
	assign s_tready   = (state_q == S_IDLE);
	assign is_reg_act = (s_tuser == ACT_ONESHOT) || (s_tuser == ACT_PERIODIC);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : 32'(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= TICK_STEP_RESET;
		end else if (cfg_wr) begin
			step_q <= pwdata[STEP_W-1:0];
		end
	end

	// result port
	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {5'd0, m_fired_q, m_slot_q};

	// entry read in the previous cycle, reset value if never written
	assign cur_s1 = vld_s1 ? rdata_s1 : RESET_ENTRY;

	stp_slot_update u_upd (
		.is_tick (act_q == ACT_TICK),
		.step    (step_q),
		.cur     (cur_s1),
		.running (running_q[idx_s1]),
		.upd     (upd)
	);

	// memory write source: registration in scan, else sweep write-back
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = upd.nxt;
		if (state_q == S_SCAN && !running_q[idx_q]) begin
			wr_en   = 1'b1;
			wr_addr = idx_q;
			wr_data = '{oneshot: (act_q == ACT_ONESHOT), period: per_q,
				remaining: $signed({{(REM_W-PERIOD_W){1'b0}}, per_q})};
		end else if (v_s1) begin
			wr_en = 1'b1;
		end
	end

	// slot memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= slot_mem[idx_q];
	end

	// control, flags and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			act_q        <= ACT_TICK;
			per_q        <= '0;
			running_q    <= '0;
			vld_q        <= '0;
			res_status_q <= ST_OK;
			res_slot_q   <= '0;
			fired_q      <= '0;
			m_valid_q    <= 1'b0;
			m_status_q   <= ST_OK;
			m_slot_q     <= '0;
			m_fired_q    <= '0;
			v_s1         <= 1'b0;
			idx_s1       <= '0;
			vld_s1       <= 1'b0;
		end else begin
			// result taken; a new one loaded in S_DONE replaces it
			if (m_valid_q && m_tready && state_q != S_DONE) begin
				m_valid_q <= 1'b0;
			end

			// read stage bookkeeping
			v_s1   <= (state_q == S_SWEEP);
			idx_s1 <= idx_q;
			vld_s1 <= vld_q[idx_q];

			// write-back of a swept slot
			if (v_s1) begin
				vld_q[idx_s1]     <= 1'b1;
				running_q[idx_s1] <= upd.run;
				if (upd.fire && 32'(idx_s1) < MASK_W) begin
					fired_q[SLOT_W'(idx_s1)] <= 1'b1;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						act_q        <= s_tuser;
						per_q        <= s_tdata[PERIOD_W-1:0];
						idx_q        <= '0;
						res_status_q <= ST_OK;
						res_slot_q   <= '0;
						fired_q      <= '0;
						if (!is_reg_act) begin
							state_q <= S_SWEEP;
						end else if (s_tdata[PERIOD_W-1:0] == '0) begin
							res_status_q <= ST_ZERO_PER;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// lowest slot that is not running
					if (!running_q[idx_q]) begin
						running_q[idx_q] <= 1'b1;
						vld_q[idx_q]     <= 1'b1;
						res_slot_q       <= SLOT_W'(idx_q);
						state_q          <= S_DONE;
					end else if (idx_q == LAST_IDX) begin
						res_status_q <= ST_POOL_FULL;
						state_q      <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SWEEP: begin
					if (idx_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q  <= 1'b1;
						m_status_q <= res_status_q;
						m_slot_q   <= res_slot_q;
						m_fired_q  <= fired_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/stp_slot_update.sv */
// Per-slot update for tick and service sweeps.
`timescale 1ns / 1ps
module stp_slot_update
	import stp_pkg::*;
(
	input  logic                is_tick,
	input  logic [STEP_W-1:0]   step,
	input  entry_t              cur,
	input  logic                running,
	output upd_t                upd
);

	logic signed [REM_W-1:0] step_ext;
	logic                    expired;

	assign step_ext = $signed({{(REM_W-STEP_W){1'b0}}, step});
	assign expired  = running && cur.remaining[REM_W-1];

	always_comb begin
		upd.nxt  = cur;
		upd.fire = 1'b0;
		upd.run  = running;
		if (is_tick) begin
			// count down while not yet negative, running or not
			if (!cur.remaining[REM_W-1]) begin
				upd.nxt.remaining = cur.remaining - step_ext;
			end
		end else if (expired) begin
			// report; periodic slots reload and keep running
			upd.fire = 1'b1;
			upd.run  = !cur.oneshot;
			if (!cur.oneshot) begin
				upd.nxt.remaining = $signed({{(REM_W-PERIOD_W){1'b0}}, cur.period});
			end
		end
	end

endmodule

/* sv/stp_checker.sv */
// Port-level checks for the software timer pool, bound to the top level.
`timescale 1ns / 1ps
module stp_checker
	import stp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// one item at a time: input closes right after a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// status is always one of the defined codes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_ZERO_PER ||
			m_tuser == ST_POOL_FULL))
		else $error("bad status code");

	// rejected registrations carry no slot and no fired bits
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata[10:0] == 11'd0)
		else $error("rejection with payload");

endmodule

bind software_timer_pool stp_checker u_stp_checker (.*);
